[rtl/ir_beacon_bearing_steer_unit_macros.svh]
// assertion macros shared by the ir beacon steering rtl
// expects clk and rst_n in the scope of each use
`ifndef IR_BEACON_BEARING_STEER_UNIT_MACROS_SVH
`define IR_BEACON_BEARING_STEER_UNIT_MACROS_SVH

// property checked on every rising edge outside reset
`define IRBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define IRBB_NEVER(lbl, cond, msg) \
  `IRBB_ASSERT(lbl, !(cond), msg)

`endif

[rtl/irbb_pkg.sv]
// shared types, constants and helpers for the ir beacon steering block
// no dependencies
package irbb_pkg;

  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_DISTANCE = 3'd0;
  localparam logic [2:0] REG_RANGE_OFFSET    = 3'd1;
  localparam logic [2:0] REG_ALIGN_WINDOW    = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT     = 3'd3;

  localparam logic [7:0] RST_TARGET_DISTANCE = 8'd30;
  localparam logic [7:0] RST_RANGE_OFFSET    = 8'd125;
  localparam logic [7:0] RST_ALIGN_WINDOW    = 8'd30;
  localparam logic [6:0] RST_SPEED_LIMIT     = 7'd16;

  // bearing constants, 10-bit two's complement; the quarter angle is 7-bit unsigned
  localparam logic signed [9:0] BASE_RIGHT = -10'sd90;
  localparam logic signed [9:0] BASE_TAIL  = 10'sd0;
  localparam logic signed [9:0] BASE_LEFT  = 10'sd90;
  localparam logic signed [9:0] BASE_HEAD  = 10'sd180;
  localparam logic signed [9:0] ANG_HALF   = 10'sd180;
  localparam logic signed [9:0] ANG_FULL   = 10'sd360;
  localparam logic [6:0]        ANG_QUARTER = 7'd90;

  localparam logic [7:0] TURN_POS = 8'h60;
  localparam logic [7:0] TURN_NEG = 8'h40;

  typedef struct packed {
    logic [7:0] target_distance;
    logic [7:0] range_offset;
    logic [7:0] align_window;
    logic [6:0] speed_limit;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_HEAD,
    ST_CMD
  } back_state_t;

  // bump a nonzero speed by two, then clip at the limit
  function automatic logic [6:0] sat_speed(input logic [31:0] v, input logic [6:0] lim);
    logic [31:0] t;
    t = v;
    if (t != 32'd0) begin
      t = t + 32'd2;
    end
    if (t > {25'd0, lim}) begin
      t = {25'd0, lim};
    end
    return t[6:0];
  endfunction

endpackage

[rtl/irbb_queue.sv]
// short queue of latched periods between front and back
// depends on irbb_pkg
module irbb_queue #(
  parameter int WIDTH = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output irbb_pkg::q_stat_t    stat
);

  localparam int DEPTH = irbb_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;

  assign stat.full  = (count_r == NW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`include "ir_beacon_bearing_steer_unit_macros.svh"

  `IRBB_NEVER(a_q_push_full, push && stat.full && !pop, "queue pushed while full")
  `IRBB_NEVER(a_q_pop_empty, pop && stat.empty, "queue popped while empty")
  `IRBB_NEVER(a_q_count_over, count_r > NW'(DEPTH), "queue count past depth")

endmodule

[rtl/irbb_front.sv]
// front end: per-tick counters and falling-edge capture of a period
// depends on irbb_pkg; feeds irbb_queue
module irbb_front #(
  parameter int COUNT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3:0]                in_rx_active,
  input  irbb_pkg::q_stat_t         q_stat,
  output logic                      q_push,
  output logic [5*COUNT_BITS-1:0]   q_data
);

  localparam int CB = COUNT_BITS;

  logic [CB-1:0] counts_r [4];
  logic [CB-1:0] counts_nxt [4];
  logic [CB-1:0] tick_r, tick_nxt;
  logic          prev_any_r;
  logic          any_rx;
  logic          fall_det;
  logic          accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign any_rx   = |in_rx_active;
  assign fall_det = prev_any_r && !any_rx;
  assign q_push   = accept && fall_det;

  always_comb begin
    tick_nxt = tick_r + 1'b1;
    for (int i = 0; i < 4; i++) begin
      counts_nxt[i] = counts_r[i] + CB'(in_rx_active[i]);
    end
  end

  assign q_data = {tick_nxt, counts_nxt[3], counts_nxt[2], counts_nxt[1], counts_nxt[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      prev_any_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        counts_r[i] <= '0;
      end
    end else if (accept) begin
      prev_any_r <= any_rx;
      if (fall_det) begin
        tick_r <= '0;
        for (int i = 0; i < 4; i++) begin
          counts_r[i] <= '0;
        end
      end else begin
        tick_r <= tick_nxt;
        for (int i = 0; i < 4; i++) begin
          counts_r[i] <= counts_nxt[i];
        end
      end
    end
  end

endmodule

[rtl/irbb_back.sv]
// back end: bearing, range and speed commands for one latched period
// depends on irbb_pkg; iterative restoring divider for the bearing ratio
module irbb_back #(
  parameter int COUNT_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  irbb_pkg::cfg_t           cfg,
  input  irbb_pkg::q_stat_t        q_stat,
  input  logic [5*COUNT_BITS-1:0]  q_data,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [8:0]        out_heading_deg,
  output logic [8:0]               out_range_sum,
  output logic signed [9:0]        out_near_range,
  output logic [1:0]               out_strongest,
  output logic [7:0]               out_period_ticks,
  output logic [6:0]               out_fwd_cmd,
  output logic [7:0]               out_turn_cmd
);

  localparam int CB  = COUNT_BITS;
  localparam int PW  = CB + 7;                     // |diff| * 90
  localparam int DW  = CB + 2;                     // divisor, sum of three counts
  localparam int RSW = CB + 1;                     // range sum
  localparam int NRW = ((RSW > 8) ? RSW : 8) + 1;  // near range, signed
  localparam int EW  = NRW + 1;                    // near range minus target
  localparam int CW  = $clog2(PW + 1);

  irbb_pkg::back_state_t state_r, state_nxt;

  logic [CB-1:0]         v_r [4];
  logic [CB-1:0]         period_r;
  logic [1:0]            idx_r;
  logic [CB-1:0]         mn_r;
  logic [RSW-1:0]        rsum_r;
  logic [DW-1:0]         d_r;
  logic [CB-1:0]         dmag_r;
  logic                  neg_r;
  logic [PW-1:0]         quo_r;
  logic [DW-1:0]         rem_r;
  logic [CW-1:0]         cnt_r;
  logic signed [9:0]     head_r;
  logic signed [NRW-1:0] nr_r;
  logic                  out_valid_r;

  logic                  out_load;

  // scan
  logic [1:0]            scan_idx;
  logic [CB-1:0]         scan_mx, scan_mn;
  // prep
  logic [CB-1:0]         v_self, v_nxt, v_prv;
  logic [CB-1:0]         c_self, c_nxt, c_prv;
  logic [DW-1:0]         d_sum;
  logic [RSW-1:0]        rsum_val;
  // divide step
  logic [DW:0]           trial;
  logic                  trial_ge;
  // head
  logic signed [9:0]     q_mag, q_s, base, h_sum, h_fix;
  logic signed [NRW-1:0] nr_val;
  // command
  logic signed [9:0]     head_mag;
  logic [7:0]            ang;
  logic [6:0]            yaw;
  logic signed [EW-1:0]  e_val;
  logic [EW-1:0]         e_mag;
  logic [6:0]            fwd_raw;
  logic                  fwd_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      irbb_pkg::ST_IDLE: if (!q_stat.empty) state_nxt = irbb_pkg::ST_SCAN;
      irbb_pkg::ST_SCAN: state_nxt = irbb_pkg::ST_PREP;
      irbb_pkg::ST_PREP: state_nxt = irbb_pkg::ST_MUL;
      irbb_pkg::ST_MUL:  state_nxt = irbb_pkg::ST_DIV;
      irbb_pkg::ST_DIV:  if (cnt_r == CW'(1)) state_nxt = irbb_pkg::ST_HEAD;
      irbb_pkg::ST_HEAD: state_nxt = irbb_pkg::ST_CMD;
      irbb_pkg::ST_CMD:  if (!out_valid_r || out_ready) state_nxt = irbb_pkg::ST_IDLE;
      default:           state_nxt = irbb_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = (state_r == irbb_pkg::ST_IDLE) && !q_stat.empty;
    out_load = (state_r == irbb_pkg::ST_CMD) && (!out_valid_r || out_ready);
  end

  // strongest (first max) and weakest
  always_comb begin
    scan_idx = 2'd0;
    scan_mx  = v_r[0];
    scan_mn  = v_r[0];
    for (int i = 1; i < 4; i++) begin
      if (v_r[i] > scan_mx) begin
        scan_mx  = v_r[i];
        scan_idx = 2'(i);
      end
      if (v_r[i] < scan_mn) begin
        scan_mn = v_r[i];
      end
    end
  end

  // strongest receiver and its two neighbours
  always_comb begin
    case (idx_r)
      2'd0: begin
        v_self = v_r[0]; v_nxt = v_r[1]; v_prv = v_r[3];
      end
      2'd1: begin
        v_self = v_r[1]; v_nxt = v_r[2]; v_prv = v_r[0];
      end
      2'd2: begin
        v_self = v_r[2]; v_nxt = v_r[3]; v_prv = v_r[1];
      end
      default: begin
        v_self = v_r[3]; v_nxt = v_r[0]; v_prv = v_r[2];
      end
    endcase
    c_self   = v_self - mn_r;
    c_nxt    = v_nxt - mn_r;
    c_prv    = v_prv - mn_r;
    d_sum    = DW'(c_self) + DW'(c_nxt) + DW'(c_prv);
    rsum_val = RSW'(({1'b0, v_prv} + {1'b0, v_nxt}) >> 1) + RSW'(v_self);
  end

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[PW-1]};
    trial_ge = (trial >= {1'b0, d_r});
  end

  always_comb begin
    q_mag = 10'(quo_r);
    q_s   = neg_r ? -q_mag : q_mag;
    case (idx_r)
      2'd0:    base = irbb_pkg::BASE_RIGHT;
      2'd1:    base = irbb_pkg::BASE_TAIL;
      2'd2:    base = irbb_pkg::BASE_LEFT;
      default: base = irbb_pkg::BASE_HEAD;
    endcase
    h_sum  = q_s + base;
    h_fix  = (h_sum > irbb_pkg::ANG_HALF) ? h_sum - irbb_pkg::ANG_FULL : h_sum;
    nr_val = $signed(NRW'(cfg.range_offset)) - $signed(NRW'(rsum_r));
  end

  always_comb begin
    head_mag = (head_r < 0) ? -head_r : head_r;
    ang      = 8'(irbb_pkg::ANG_HALF - head_mag);
    yaw      = irbb_pkg::sat_speed(32'(ang >> 2), cfg.speed_limit);
    e_val    = EW'(nr_r) - $signed({{(EW - 8){1'b0}}, cfg.target_distance});
    e_mag    = (e_val < 0) ? EW'(-e_val) : EW'(e_val);
    fwd_raw  = irbb_pkg::sat_speed(32'(e_mag), cfg.speed_limit);
    fwd_ok   = (ang <= cfg.align_window) && (e_val > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irbb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int i = 0; i < 4; i++) begin
        v_r[i] <= q_data[i*CB +: CB];
      end
      period_r <= q_data[4*CB +: CB];
    end
    if (state_r == irbb_pkg::ST_SCAN) begin
      idx_r <= scan_idx;
      mn_r  <= scan_mn;
    end
    if (state_r == irbb_pkg::ST_PREP) begin
      d_r    <= (d_sum == '0) ? DW'(1) : d_sum;
      neg_r  <= (c_nxt < c_prv);
      dmag_r <= (c_nxt < c_prv) ? c_prv - c_nxt : c_nxt - c_prv;
      rsum_r <= rsum_val;
    end
    if (state_r == irbb_pkg::ST_MUL) begin
      quo_r <= PW'(dmag_r) * PW'(irbb_pkg::ANG_QUARTER);
      rem_r <= '0;
      cnt_r <= CW'(PW);
    end
    if (state_r == irbb_pkg::ST_DIV) begin
      rem_r <= trial_ge ? DW'(trial - {1'b0, d_r}) : DW'(trial);
      quo_r <= {quo_r[PW-2:0], trial_ge};
      cnt_r <= cnt_r - 1'b1;
    end
    if (state_r == irbb_pkg::ST_HEAD) begin
      head_r <= h_fix;
      nr_r   <= nr_val;
    end
    if (out_load) begin
      out_heading_deg  <= 9'(head_r);
      out_range_sum    <= 9'(rsum_r);
      out_near_range   <= 10'(nr_r);
      out_strongest    <= idx_r;
      out_period_ticks <= 8'(period_r);
      out_fwd_cmd      <= fwd_ok ? fwd_raw : 7'd0;
      out_turn_cmd     <= (head_r > 0) ? irbb_pkg::TURN_POS + 8'(yaw)
                                       : irbb_pkg::TURN_NEG + 8'(yaw);
    end
  end

  assign out_valid = out_valid_r;

`include "ir_beacon_bearing_steer_unit_macros.svh"

  `IRBB_NEVER(a_div_cnt_live, (state_r == irbb_pkg::ST_DIV) && (cnt_r == '0), "divider count ran out")
  `IRBB_ASSERT(a_out_from_cmd, $rose(out_valid_r) |-> $past(state_r == irbb_pkg::ST_CMD), "result without command step")
  `IRBB_ASSERT(a_head_range, (state_r == irbb_pkg::ST_CMD) |-> ((head_r <= 180) && (head_r >= -180)), "bearing out of range")

endmodule

[rtl/ir_beacon_bearing_steer_unit.sv]
// channel   dir  handshake              payload
// in        in   in_valid/in_ready      in_rx_active
// out       out  out_valid/out_ready    heading, range, near range, strongest, period, cmds
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a tick is accepted whenever the period queue has room; only a falling
// edge of the detect flags queues a result
// each result runs through scan, prep, multiply, divide, heading and command states
// in the back end, with the one-bit-per-cycle divider; results wait in the output register
// reset is synchronous and clears counters, queue and state; no clearing pass
// top level: config registers, front end, period queue, back end
// depends on irbb_pkg, irbb_front, irbb_queue, irbb_back
module ir_beacon_bearing_steer_unit #(
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_rx_active,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [8:0] out_heading_deg,
  output logic [8:0]        out_range_sum,
  output logic signed [9:0] out_near_range,
  output logic [1:0]        out_strongest,
  output logic [7:0]        out_period_ticks,
  output logic [6:0]        out_fwd_cmd,
  output logic [7:0]        out_turn_cmd,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam int QW = 5 * COUNT_BITS;

  irbb_pkg::cfg_t    cfg_r;
  irbb_pkg::q_stat_t q_stat;
  logic              q_push, q_pop;
  logic [QW-1:0]     q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_distance <= irbb_pkg::RST_TARGET_DISTANCE;
      cfg_r.range_offset    <= irbb_pkg::RST_RANGE_OFFSET;
      cfg_r.align_window    <= irbb_pkg::RST_ALIGN_WINDOW;
      cfg_r.speed_limit     <= irbb_pkg::RST_SPEED_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irbb_pkg::REG_TARGET_DISTANCE: cfg_r.target_distance <= cfg_data;
        irbb_pkg::REG_RANGE_OFFSET:    cfg_r.range_offset    <= cfg_data;
        irbb_pkg::REG_ALIGN_WINDOW:    cfg_r.align_window    <= cfg_data;
        irbb_pkg::REG_SPEED_LIMIT:     cfg_r.speed_limit     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  irbb_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_active (in_rx_active),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  irbb_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  irbb_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heading_deg  (out_heading_deg),
    .out_range_sum    (out_range_sum),
    .out_near_range   (out_near_range),
    .out_strongest    (out_strongest),
    .out_period_ticks (out_period_ticks),
    .out_fwd_cmd      (out_fwd_cmd),
    .out_turn_cmd     (out_turn_cmd)
  );

endmodule

[dv/ir_beacon_bearing_steer_unit_tb.sv]
// self-checking testbench for ir_beacon_bearing_steer_unit: a directed tick table,
// then random and long detect bursts; results checked against typed rows or an in-bench predictor
// depends on irbb_pkg and the rtl of the unit
`timescale 1ns / 1ps

module ir_beacon_bearing_steer_unit_tb;

  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 38;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;

  // receiver indexes
  localparam logic [1:0] RX_RIGHT = 2'd0;
  localparam logic [1:0] RX_TAIL  = 2'd1;
  localparam logic [1:0] RX_LEFT  = 2'd2;
  localparam logic [1:0] RX_HEAD  = 2'd3;

  // register indexes the block must ignore
  localparam logic [2:0] REG_SPARE_LO = 3'd4;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [8:0] heading;
    logic [8:0]        range_sum;
    logic signed [9:0] near_range;
    logic [1:0]        strongest;
    logic [7:0]        period;
    logic [6:0]        fwd;
    logic [7:0]        turn;
  } steer_result_t;

  typedef struct packed {
    logic [3:0]    flags;
    logic          typed;
    steer_result_t res;
  } tick_row_t;

  // typed results follow the reset register values
  localparam tick_row_t DIRECTED [N_DIRECTED] = '{
    '{4'b0000, 1'b0, '0},
    '{4'b0001, 1'b0, '0},
    '{4'b0000, 1'b1, '{-9'sd90, 9'd1, 10'sd124, RX_RIGHT, 8'd3, 7'd0, 8'h50}},
    '{4'b0010, 1'b0, '0},
    '{4'b0000, 1'b1, '{9'sd0, 9'd1, 10'sd124, RX_TAIL, 8'd2, 7'd0, 8'h50}},
    '{4'b0100, 1'b0, '0},
    '{4'b0000, 1'b1, '{9'sd90, 9'd1, 10'sd124, RX_LEFT, 8'd2, 7'd0, 8'h70}},
    '{4'b1000, 1'b0, '0},
    '{4'b0000, 1'b1, '{9'sd180, 9'd1, 10'sd124, RX_HEAD, 8'd2, 7'd16, 8'h60}},
    '{4'b1111, 1'b0, '0},
    // all equal: zero divisor and a four-way tie
    '{4'b0000, 1'b1, '{-9'sd90, 9'd2, 10'sd123, RX_RIGHT, 8'd2, 7'd0, 8'h50}},
    '{4'b1001, 1'b0, '0},
    '{4'b1011, 1'b0, '0},
    '{4'b1010, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0101, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b1100, 1'b0, '0},
    '{4'b1110, 1'b0, '0},
    '{4'b0110, 1'b0, '0},
    '{4'b0100, 1'b0, '0},
    '{4'b0000, 1'b0, '0},
    '{4'b0011, 1'b0, '0},
    '{4'b0000, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [3:0]        in_rx_active;
  logic              out_valid;
  logic              out_ready;
  logic signed [8:0] out_heading_deg;
  logic [8:0]        out_range_sum;
  logic signed [9:0] out_near_range;
  logic [1:0]        out_strongest;
  logic [7:0]        out_period_ticks;
  logic [6:0]        out_fwd_cmd;
  logic [7:0]        out_turn_cmd;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [7:0]        cfg_data;

  // predictor state and register copies
  logic [7:0] hit_cnt [4];
  logic [7:0] tick_cnt;
  logic       was_any;
  logic [7:0] cfg_target;
  logic [7:0] cfg_offset;
  logic [7:0] cfg_align;
  logic [6:0] cfg_speed;

  steer_result_t steer_due [$];
  steer_result_t mon_want;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int results_seen;
  int reg_writes;
  int mismatches;
  int cycle_cnt;
  int phase_start;

  ir_beacon_bearing_steer_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_active     (in_rx_active),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heading_deg  (out_heading_deg),
    .out_range_sum    (out_range_sum),
    .out_near_range   (out_near_range),
    .out_strongest    (out_strongest),
    .out_period_ticks (out_period_ticks),
    .out_fwd_cmd      (out_fwd_cmd),
    .out_turn_cmd     (out_turn_cmd),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int speed_clip(input int x);
    if (x > 0) begin
      x = x + 2;
    end
    if (x > int'(cfg_speed)) begin
      x = int'(cfg_speed);
    end
    return x;
  endfunction

  // advance the counters by one tick; returns 1 when the detect flags fell
  function automatic bit track_tick(input logic [3:0] flags, output steer_result_t res);
    int v [4];
    int c [4];
    int idx, mx, mn, d, diff, base, hd, rs, nr, yaw, fwd, off_front, mag;
    logic any;
    res = '0;
    tick_cnt = tick_cnt + 8'd1;
    for (int i = 0; i < 4; i++) begin
      if (flags[i]) begin
        hit_cnt[i] = hit_cnt[i] + 8'd1;
      end
    end
    any = |flags;
    if (!(was_any && !any)) begin
      was_any = any;
      return 1'b0;
    end
    was_any = any;
    for (int i = 0; i < 4; i++) begin
      v[i] = int'(hit_cnt[i]);
      hit_cnt[i] = 8'd0;
    end
    idx = 0;
    mx = v[0];
    mn = v[0];
    for (int i = 1; i < 4; i++) begin
      if (v[i] > mx) begin
        mx = v[i];
        idx = i;
      end
      if (v[i] < mn) begin
        mn = v[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      c[i] = v[i] - mn;
    end
    d = c[(idx + 3) % 4] + c[(idx + 1) % 4] + c[idx];
    rs = ((v[(idx + 3) % 4] + v[(idx + 1) % 4]) >>> 1) + v[idx];
    if (d == 0) begin
      d = 1;
    end
    case (idx[1:0])
      RX_RIGHT: begin diff = c[RX_TAIL] - c[RX_HEAD];  base = -90; end
      RX_TAIL:  begin diff = c[RX_LEFT] - c[RX_RIGHT]; base = 0;   end
      RX_LEFT:  begin diff = c[RX_HEAD] - c[RX_TAIL];  base = 90;  end
      default:  begin diff = c[RX_RIGHT] - c[RX_LEFT]; base = 180; end
    endcase
    hd = (diff * 90) / d + base;
    if (hd > 180) begin
      hd = hd - 360;
    end
    nr = int'(cfg_offset) - rs;
    off_front = 180 - (hd < 0 ? -hd : hd);
    yaw = speed_clip(off_front / 4);
    mag = nr - int'(cfg_target);
    fwd = speed_clip(mag < 0 ? -mag : mag);
    if (!(off_front <= int'(cfg_align) && nr > int'(cfg_target))) begin
      fwd = 0;
    end
    res.heading    = hd[8:0];
    res.range_sum  = rs[8:0];
    res.near_range = nr[9:0];
    res.strongest  = idx[1:0];
    res.period     = tick_cnt;
    res.fwd        = fwd[6:0];
    res.turn       = (hd > 0 ? irbb_pkg::TURN_POS : irbb_pkg::TURN_NEG) + yaw[7:0];
    tick_cnt = 8'd0;
    return 1'b1;
  endfunction

  function automatic void note_reg_write(input logic [2:0] idx, input logic [7:0] data);
    case (idx)
      irbb_pkg::REG_TARGET_DISTANCE: cfg_target = data;
      irbb_pkg::REG_RANGE_OFFSET:    cfg_offset = data;
      irbb_pkg::REG_ALIGN_WINDOW:    cfg_align  = data;
      irbb_pkg::REG_SPEED_LIMIT:     cfg_speed  = data[6:0];
      default: ;
    endcase
  endfunction

  task automatic program_regs(input logic [7:0] td, input logic [7:0] ro,
                              input logic [7:0] aw, input logic [7:0] sl);
    logic [2:0] idxs [5];
    logic [7:0] vals [5];
    idxs[0] = irbb_pkg::REG_TARGET_DISTANCE; vals[0] = td;
    idxs[1] = irbb_pkg::REG_RANGE_OFFSET;    vals[1] = ro;
    idxs[2] = 3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
    vals[2] = 8'($urandom);
    idxs[3] = irbb_pkg::REG_ALIGN_WINDOW;    vals[3] = aw;
    idxs[4] = irbb_pkg::REG_SPEED_LIMIT;     vals[4] = sl;
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      note_reg_write(idxs[k], vals[k]);
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic [3:0] flags, input logic typed,
                           input steer_result_t typed_res);
    steer_result_t r;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_active <= flags;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (track_tick(flags, r)) begin
      steer_due.push_back(typed ? typed_res : r);
    end
  endtask

  // a detect period (burst with per-receiver hit odds, then the fall) or 1 to 6 random ticks
  task automatic random_burst();
    int len, dom;
    int pct [4];
    logic [3:0] f;
    if ($urandom_range(0, 99) < 85) begin
      len = $urandom_range(1, 12);
      dom = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0:       pct[i] = 10;
          1:       pct[i] = 40;
          2:       pct[i] = 80;
          default: pct[i] = 100;
        endcase
      end
      repeat (len) begin
        f = 4'b0000;
        for (int i = 0; i < 4; i++) begin
          f[i] = ($urandom_range(0, 99) < pct[i]);
        end
        if (f == 4'b0000) begin
          f[dom] = 1'b1;
        end
        send_tick(f, 1'b0, '0);
      end
      send_tick(4'b0000, 1'b0, '0);
      repeat ($urandom_range(0, 3)) send_tick(4'b0000, 1'b0, '0);
    end else begin
      repeat ($urandom_range(1, 6)) send_tick(4'($urandom_range(0, 15)), 1'b0, '0);
    end
  endtask

  // long detect period: high counts, wrapping the 8-bit counters when it runs past 255
  task automatic long_burst(input int lo, input int hi);
    logic [3:0] f;
    repeat ($urandom_range(lo, hi)) begin
      f = 4'b1111;
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          f[i] = 1'b0;
        end
      end
      if (f == 4'b0000) begin
        f = 4'b1000;
      end
      send_tick(f, 1'b0, '0);
    end
    send_tick(4'b0000, 1'b0, '0);
  endtask

  task automatic settle();
    while (steer_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (steer_due.size() == 0) begin
        $display("%0t: result with none expected, heading %0d strongest %0d",
                 $time, out_heading_deg, out_strongest);
        mismatches++;
      end else begin
        mon_want = steer_due.pop_front();
        check_field("heading_deg",  mon_want.heading,    out_heading_deg);
        check_field("range_sum",    mon_want.range_sum,  out_range_sum);
        check_field("near_range",   mon_want.near_range, out_near_range);
        check_field("strongest",    mon_want.strongest,  out_strongest);
        check_field("period_ticks", mon_want.period,     out_period_ticks);
        check_field("fwd_cmd",      mon_want.fwd,        out_fwd_cmd);
        check_field("turn_cmd",     mon_want.turn,       out_turn_cmd);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, steer_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_rx_active <= 4'b0000;
    cfg_valid    <= 1'b0;
    cfg_index    <= irbb_pkg::REG_TARGET_DISTANCE;
    cfg_data     <= 8'd0;
    for (int i = 0; i < 4; i++) begin
      hit_cnt[i] = 8'd0;
    end
    tick_cnt   = 8'd0;
    was_any    = 1'b0;
    cfg_target = 8'd30;
    cfg_offset = 8'd125;
    cfg_align  = 8'd30;
    cfg_speed  = 7'd16;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_tick(DIRECTED[k].flags, DIRECTED[k].typed, DIRECTED[k].res);
    end
    in_valid <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      case (p)
        0:       program_regs(8'd0, 8'd0, 8'd0, 8'd0);
        1:       program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2:       program_regs(8'($urandom), 8'($urandom), 8'd180, 8'($urandom));
        default: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (p == 2) begin
        long_burst(200, 250);
      end
      if (p == 5) begin
        long_burst(256, 300);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_burst();
      in_valid <= 1'b0;
    end

    settle();
    @(negedge clk);
    $display("covered %0d ticks over %0d register settings and %0d register writes",
             items_sent, N_PHASES + 1, reg_writes);
    $display("checked %0d steering results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
